### design/slwd_pkg.sv
// ----------------------------------------------------------------------------
// slwd_pkg
// Shared types and constants of the sharded loop work dispatcher.
// ----------------------------------------------------------------------------
package slwd_pkg;

  localparam int MAX_SHARD_COUNT_DEF = 8;

  localparam int DATA_W   = 32;
  localparam int WORKER_W = 10;
  localparam int PORT_SHARD_W = 3;
  localparam int DEGREE_W = 11;
  localparam int CFG_IDX_W = 1;
  localparam int STEP_W   = 6;

  localparam logic OP_BEGIN = 1'b0;
  localparam logic OP_CLAIM = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE = 1'b1;

  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] dividend;
    logic [DATA_W-1:0] divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] quo;
    logic [DATA_W-1:0] rem;
  } div_rsp_t;

  typedef struct packed {
    logic [DATA_W:0]   pos;
    logic [DATA_W-1:0] stop;
  } shard_ent_t;

endpackage

### design/slwd_div.sv
// ----------------------------------------------------------------------------
// slwd_div
// Restoring divider, one quotient bit per cycle, run for a chosen number of
// steps starting from the top bit of the dividend.
// ----------------------------------------------------------------------------
module slwd_div (
  input  logic               clk,
  input  logic               rst_n,
  input  slwd_pkg::div_req_t req,
  output slwd_pkg::div_rsp_t rsp
);
  import slwd_pkg::*;

  logic                busy_r;
  logic                done_r;
  logic [STEP_W-1:0]   cnt_r;
  logic [DATA_W-1:0]   dvd_r;
  logic [DATA_W-1:0]   dsr_r;
  logic [DATA_W-1:0]   rem_r;
  logic [DATA_W-1:0]   quo_r;
  logic [DATA_W:0]     trial;
  logic                fits;

  assign trial = {rem_r, dvd_r[DATA_W-1]};
  assign fits  = trial >= {1'b0, dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.steps;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == STEP_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= req.dividend;
      dsr_r <= req.divisor;
      rem_r <= '0;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DATA_W-2:0], 1'b0};
      quo_r <= {quo_r[DATA_W-2:0], fits};
      if (fits) begin
        rem_r <= DATA_W'(trial - {1'b0, dsr_r});
      end else begin
        rem_r <= trial[DATA_W-1:0];
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;
  assign rsp.rem  = rem_r;

endmodule

### design/sharded_loop_work_dispatcher_core.sv
// ----------------------------------------------------------------------------
// sharded_loop_work_dispatcher_core
// Splits a loop's iteration space into shards on begin and hands out blocks
// of iterations to workers on claim.
// ----------------------------------------------------------------------------
// One request is handled at a time; in_ready is high only while the
// sequencer is idle, and a finished result waits in the output register
// without holding off the next request. A begin runs two 32-step divisions
// on the shared restoring divider, one multiply state and a fill sweep over
// all MAX_SHARD_COUNT entries of the shard table. A claim runs a 10-step
// division for the home shard, a 3-step one when it starts at its current
// shard, then a table read and a check for each shard visited. A result that
// finds the output register still full holds the sequencer until out_ready.
// The shard table is cleared by reset through per-entry valid bits.
module sharded_loop_work_dispatcher_core #(
  parameter int MAX_SHARD_COUNT = slwd_pkg::MAX_SHARD_COUNT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [slwd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [slwd_pkg::DATA_W-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                in_operation,
  input  logic [slwd_pkg::WORKER_W-1:0]       in_worker_index,
  input  logic [slwd_pkg::PORT_SHARD_W-1:0]   in_current_shard,
  input  logic                                in_start_at_home,
  input  logic [slwd_pkg::DATA_W-1:0]         in_claim_size,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic                                out_granted,
  output logic [slwd_pkg::DATA_W-1:0]         out_range_start,
  output logic [slwd_pkg::DATA_W-1:0]         out_range_end,
  output logic [slwd_pkg::PORT_SHARD_W-1:0]   out_next_shard,
  output logic [slwd_pkg::PORT_SHARD_W-1:0]   out_home_shard
);
  import slwd_pkg::*;

  localparam int SW = (MAX_SHARD_COUNT > 1) ? $clog2(MAX_SHARD_COUNT) : 1;
  localparam int CW = $clog2(MAX_SHARD_COUNT + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_SHARD_COUNT);
  localparam logic [SW-1:0] LAST_IDX = SW'(MAX_SHARD_COUNT - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DIV1 = 4'd1;
  localparam logic [3:0] S_DIV2 = 4'd2;
  localparam logic [3:0] S_MUL  = 4'd3;
  localparam logic [3:0] S_FILL = 4'd4;
  localparam logic [3:0] S_HOME = 4'd5;
  localparam logic [3:0] S_CUR  = 4'd6;
  localparam logic [3:0] S_RD   = 4'd7;
  localparam logic [3:0] S_CHK  = 4'd8;
  localparam logic [3:0] S_DONE = 4'd9;

  logic [3:0]          state_r, state_nxt;
  logic [DATA_W-1:0]   total_r;
  logic [DEGREE_W-1:0] degree_r;
  logic [CW-1:0]       count_r;
  logic [MAX_SHARD_COUNT-1:0] vld_r;

  logic                at_home_r;
  logic [PORT_SHARD_W-1:0] cur_r;
  logic [DATA_W-1:0]   size_r;
  logic [DATA_W-1:0]   quo2_r;
  logic [DATA_W-1:0]   per_r;
  logic [DATA_W-1:0]   acc_r;
  logic [SW-1:0]       fill_idx_r;
  logic [SW-1:0]       home_r;
  logic [SW-1:0]       shard_r;

  logic                res_granted_r;
  logic [DATA_W-1:0]   res_start_r;
  logic [DATA_W-1:0]   res_end_r;
  logic [SW-1:0]       res_next_r;
  logic [SW-1:0]       res_home_r;
  logic                out_valid_r;

  shard_ent_t          shard_mem [MAX_SHARD_COUNT];
  shard_ent_t          rd_ent_r;
  logic                rd_vld_r;
  logic                mem_we;
  logic [SW-1:0]       mem_waddr;
  shard_ent_t          mem_wdata;

  div_req_t            div_req;
  div_rsp_t            div_rsp;

  logic [CW-1:0]       cnt_blk;
  logic [CW-1:0]       cnt_new;
  logic [DEGREE_W-1:0] deg_eff;
  logic [CW-1:0]       fill_p1;
  logic [CW-1:0]       shard_p1;
  logic [SW-1:0]       shard_wrap;
  logic [DATA_W:0]     chk_pos;
  logic [DATA_W-1:0]   chk_stop;
  logic [DATA_W:0]     chk_sum;
  logic                chk_hit;
  logic                in_acc;
  logic [DATA_W-1:0]   in_size;

  slwd_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_ready = (state_r == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_size  = (in_claim_size == '0) ? DATA_W'(1) : in_claim_size;

  always_comb begin
    deg_eff = (degree_r == '0) ? DEGREE_W'(1) : degree_r;
    if (div_rsp.quo == '0) begin
      cnt_blk = CW'(1);
    end else if (div_rsp.quo < DATA_W'(MAX_SHARD_COUNT)) begin
      cnt_blk = div_rsp.quo[CW-1:0];
    end else begin
      cnt_blk = MAX_C;
    end
    cnt_new = (DEGREE_W'(cnt_blk) > deg_eff) ? deg_eff[CW-1:0] : cnt_blk;
  end

  assign fill_p1    = CW'(fill_idx_r) + CW'(1);
  assign shard_p1   = CW'(shard_r) + CW'(1);
  assign shard_wrap = (shard_p1 == count_r) ? '0 : shard_p1[SW-1:0];

  assign chk_pos  = rd_vld_r ? rd_ent_r.pos  : '0;
  assign chk_stop = rd_vld_r ? rd_ent_r.stop : '0;
  assign chk_hit  = chk_pos < {1'b0, chk_stop};
  assign chk_sum  = chk_pos + {1'b0, size_r};

  always_comb begin
    div_req = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          div_req.start   = 1'b1;
          if (in_operation == OP_BEGIN) begin
            div_req.dividend = total_r;
            div_req.divisor  = in_size;
            div_req.steps    = STEP_W'(DATA_W);
          end else begin
            div_req.dividend = {in_worker_index, (DATA_W - WORKER_W)'(0)};
            div_req.divisor  = DATA_W'(count_r);
            div_req.steps    = STEP_W'(WORKER_W);
          end
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          div_req.start    = 1'b1;
          div_req.dividend = div_rsp.quo;
          div_req.divisor  = DATA_W'(cnt_new);
          div_req.steps    = STEP_W'(DATA_W);
        end
      end
      S_HOME: begin
        if (div_rsp.done && !at_home_r) begin
          div_req.start    = 1'b1;
          div_req.dividend = {cur_r, (DATA_W - PORT_SHARD_W)'(0)};
          div_req.divisor  = DATA_W'(count_r);
          div_req.steps    = STEP_W'(PORT_SHARD_W);
        end
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = shard_r;
    mem_wdata = '0;
    if (state_r == S_FILL) begin
      mem_we    = 1'b1;
      mem_waddr = fill_idx_r;
      if (CW'(fill_idx_r) < count_r) begin
        mem_wdata.pos  = {1'b0, acc_r};
        mem_wdata.stop = (fill_p1 == count_r) ? total_r : acc_r + per_r;
      end
    end else if (state_r == S_CHK && chk_hit) begin
      mem_we         = 1'b1;
      mem_wdata.pos  = chk_sum;
      mem_wdata.stop = chk_stop;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (in_operation == OP_BEGIN) ? S_DIV1 : S_HOME;
        end
      end
      S_DIV1: begin
        if (div_rsp.done) begin
          state_nxt = S_DIV2;
        end
      end
      S_DIV2: begin
        if (div_rsp.done) begin
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        state_nxt = S_FILL;
      end
      S_FILL: begin
        if (fill_idx_r == LAST_IDX) begin
          state_nxt = S_DONE;
        end
      end
      S_HOME: begin
        if (div_rsp.done) begin
          state_nxt = at_home_r ? S_RD : S_CUR;
        end
      end
      S_CUR: begin
        if (div_rsp.done) begin
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (chk_hit || shard_wrap == home_r) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      degree_r    <= DEGREE_W'(1);
      count_r     <= CW'(1);
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_TOTAL:  total_r  <= cfg_data;
          CFG_DEGREE: degree_r <= cfg_data[DEGREE_W-1:0];
          default:    total_r  <= total_r;
        endcase
      end
      if (state_r == S_DIV1 && div_rsp.done) begin
        count_r <= cnt_new;
      end
      if (mem_we) begin
        vld_r[mem_waddr] <= 1'b1;
      end
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      shard_mem[mem_waddr] <= mem_wdata;
    end
    rd_ent_r <= shard_mem[shard_r];
    rd_vld_r <= vld_r[shard_r];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      at_home_r     <= in_start_at_home;
      cur_r         <= in_current_shard;
      size_r        <= in_size;
      res_granted_r <= 1'b0;
      res_start_r   <= '0;
      res_end_r     <= '0;
      res_next_r    <= '0;
      res_home_r    <= '0;
    end
    if (state_r == S_DIV2 && div_rsp.done) begin
      quo2_r <= div_rsp.quo;
    end
    if (state_r == S_MUL) begin
      per_r      <= DATA_W'(quo2_r * size_r);
      acc_r      <= '0;
      fill_idx_r <= '0;
    end
    if (state_r == S_FILL) begin
      acc_r      <= acc_r + per_r;
      fill_idx_r <= fill_idx_r + 1'b1;
    end
    if (state_r == S_HOME && div_rsp.done) begin
      home_r     <= div_rsp.rem[SW-1:0];
      res_home_r <= div_rsp.rem[SW-1:0];
      if (at_home_r) begin
        shard_r <= div_rsp.rem[SW-1:0];
      end
    end
    if (state_r == S_CUR && div_rsp.done) begin
      shard_r <= div_rsp.rem[SW-1:0];
    end
    if (state_r == S_CHK) begin
      if (chk_hit) begin
        res_granted_r <= 1'b1;
        res_start_r   <= chk_pos[DATA_W-1:0];
        res_end_r     <= (chk_sum > {1'b0, chk_stop}) ? chk_stop : chk_sum[DATA_W-1:0];
        res_next_r    <= shard_r;
      end else if (shard_wrap == home_r) begin
        res_next_r <= home_r;
      end else begin
        shard_r <= shard_wrap;
      end
    end
    if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
      out_granted     <= res_granted_r;
      out_range_start <= res_start_r;
      out_range_end   <= res_end_r;
      out_next_shard  <= PORT_SHARD_W'(res_next_r);
      out_home_shard  <= PORT_SHARD_W'(res_home_r);
    end
  end

  assign out_valid = out_valid_r;

endmodule
